[rtl/uvs_pkg.sv]
// Shared types, constants and arithmetic helpers for the UV sphere vertex generator.
`timescale 1ns / 1ps

package uvs_pkg;

	localparam int CNT_W      = 11;
	localparam int IDX_W      = 11;
	localparam int POS_W      = 16;
	localparam int TEX_W      = 17;
	localparam int CRN_W      = 21;
	localparam int CFG_IDX_W  = 2;
	localparam int ANG_W      = 20;
	localparam int QW         = 22;
	localparam int MAG_W      = 31;
	localparam int SIN_LAT    = 7;
	localparam int SIDE_LAT   = QW + 1 + SIN_LAT + 1;
	localparam int TEX_LAT    = SIN_LAT + 2;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int MAX_DIVISIONS = 1024;
	localparam logic [CNT_W-1:0] MIN_SLICES = 11'd3;
	localparam logic [CNT_W-1:0] MIN_STACKS = 11'd2;

	localparam logic [CNT_W-1:0] SLICE_RESET = 11'd32;
	localparam logic [CNT_W-1:0] STACK_RESET = 11'd16;

	localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STACK_COUNT = 2'd1;

	localparam logic [ANG_W-1:0] QUARTER_TURN = 20'h40000;
	localparam logic [MAG_W-1:0] ONE_Q30      = 31'h4000_0000;

	// Taylor terms of sin(pi/2 * t), Q30
	localparam logic [MAG_W-1:0] SIN_C0 = 31'd1686629713;
	localparam logic [MAG_W-1:0] SIN_C1 = 31'd693598668;
	localparam logic [MAG_W-1:0] SIN_C2 = 31'd85569306;
	localparam logic [MAG_W-1:0] SIN_C3 = 31'd5026995;
	localparam logic [MAG_W-1:0] SIN_C4 = 31'd172272;

	typedef struct packed {
		logic             in_range;
		logic             quad_valid;
		logic [CRN_W-1:0] corner_a;
		logic [CRN_W-1:0] corner_b;
		logic [CRN_W-1:0] corner_c;
		logic [CRN_W-1:0] corner_d;
	} side_t;

	typedef struct packed {
		logic [IDX_W-1:0] slice;
		logic [CNT_W-1:0] slices;
		logic [IDX_W-1:0] stack;
		logic [CNT_W-1:0] stacks;
		side_t            side;
	} req_t;

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
		input logic [CNT_W-1:0] lo);
		logic [CNT_W-1:0] r;
		if (v < lo) r = lo;
		else if (v > CNT_W'(MAX_DIVISIONS)) r = CNT_W'(MAX_DIVISIONS);
		else r = v;
		return r;
	endfunction

	// Q30 product, rounded to nearest
	function automatic logic [MAG_W-1:0] mul_q30(input logic [MAG_W-1:0] a,
		input logic [MAG_W-1:0] b);
		logic [2*MAG_W:0] pr;
		pr = ({32'd0, a} * {32'd0, b}) + (63'd1 << 29);
		return pr[60:30];
	endfunction

	// saturate a magnitude to Q15 and apply the sign
	function automatic logic signed [POS_W-1:0] sat_sign(input logic [17:0] m,
		input logic neg);
		logic [POS_W-1:0] s;
		s = (m > 18'd32767) ? 16'd32767 : m[POS_W-1:0];
		if (neg) s = 16'd0 - s;
		return signed'(s);
	endfunction

endpackage

[rtl/uv_sphere_vertex_generator_core.sv]
// Top level of the UV sphere vertex generator: config registers, front end, queue, back end.
`timescale 1ns / 1ps
//
//  channel   signals                                  direction  handshake
//  request   start, busy, stack_index, slice_index    in         start & !busy
//  result    done, pos_*, tex_*, corner_*, flags      out        done strobe, one cycle
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in        cfg_valid & cfg_ready
//
//  One request per clock while busy is low. Results pass the 22-stage quotient pipeline
//  (one bit per stage), the 7-stage sine pipeline and the product and output registers.
//  Reset clears the control state and loads 32 slices and 16 stacks.
//  busy only rises if the queue fills; results cannot be held off downstream.
//  cfg_ready is always high; counts are applied to requests accepted after the write.

module uv_sphere_vertex_generator_core #(
	parameter int QUEUE_DEPTH = uvs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [uvs_pkg::IDX_W-1:0]         stack_index,
	input  logic [uvs_pkg::IDX_W-1:0]         slice_index,
	output logic                              done,
	output logic signed [uvs_pkg::POS_W-1:0]  pos_x,
	output logic signed [uvs_pkg::POS_W-1:0]  pos_y,
	output logic signed [uvs_pkg::POS_W-1:0]  pos_z,
	output logic [uvs_pkg::TEX_W-1:0]         tex_u,
	output logic [uvs_pkg::TEX_W-1:0]         tex_v,
	output logic [uvs_pkg::CRN_W-1:0]         corner_a,
	output logic [uvs_pkg::CRN_W-1:0]         corner_b,
	output logic [uvs_pkg::CRN_W-1:0]         corner_c,
	output logic [uvs_pkg::CRN_W-1:0]         corner_d,
	output logic                              quad_valid,
	output logic                              in_range,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [uvs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [uvs_pkg::CNT_W-1:0]         cfg_data
);
	import uvs_pkg::*;

	logic [CNT_W-1:0] slice_cnt_q;
	logic [CNT_W-1:0] stack_cnt_q;
	logic             push;
	logic             full;
	logic             empty;
	req_t             f_req;
	req_t             q_req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_cnt_q <= SLICE_RESET;
			stack_cnt_q <= STACK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SLICE_COUNT: slice_cnt_q <= cfg_data;
				REG_STACK_COUNT: stack_cnt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	uvs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.stack_index (stack_index),
		.slice_index (slice_index),
		.slice_cnt   (slice_cnt_q),
		.stack_cnt   (stack_cnt_q),
		.full        (full),
		.busy        (busy),
		.push        (push),
		.req         (f_req)
	);

	uvs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_req),
		.pop    (1'b1),
		.full   (full),
		.empty  (empty),
		.rdata  (q_req)
	);

	uvs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (!empty),
		.req        (q_req),
		.done       (done),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.tex_u      (tex_u),
		.tex_v      (tex_v),
		.corner_a   (corner_a),
		.corner_b   (corner_b),
		.corner_c   (corner_c),
		.corner_d   (corner_d),
		.quad_valid (quad_valid),
		.in_range   (in_range)
	);

endmodule

[rtl/uvs_front.sv]
// Front end: takes requests, clamps the grid counts, classifies the point, builds corner indices.
`timescale 1ns / 1ps

module uvs_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [uvs_pkg::IDX_W-1:0] stack_index,
	input  logic [uvs_pkg::IDX_W-1:0] slice_index,
	input  logic [uvs_pkg::CNT_W-1:0] slice_cnt,
	input  logic [uvs_pkg::CNT_W-1:0] stack_cnt,
	input  logic                     full,
	output logic                     busy,
	output logic                     push,
	output uvs_pkg::req_t            req
);
	import uvs_pkg::*;

	logic             v_s1;
	req_t             req_s1;
	req_t             req_c;
	logic             take;
	logic [CNT_W-1:0] slices;
	logic [CNT_W-1:0] stacks;
	logic [CNT_W-1:0] row_len;
	logic [2*CNT_W-1:0] prod;
	logic [CRN_W-1:0] ca;
	logic [CRN_W-1:0] cc;
	logic             inr;
	logic             qv;

	assign busy = v_s1 && full;
	assign take = start && !busy;
	assign push = v_s1 && !full;
	assign req  = req_s1;

	always_comb begin
		slices  = clamp_count(slice_cnt, MIN_SLICES);
		stacks  = clamp_count(stack_cnt, MIN_STACKS);
		row_len = slices + 11'd1;
		inr     = (stack_index <= stacks) && (slice_index <= slices);
		qv      = (stack_index < stacks) && (slice_index < slices);
		prod    = {11'd0, stack_index} * {11'd0, row_len};
		ca      = CRN_W'(prod + {11'd0, slice_index});
		cc      = ca + {10'd0, row_len};
		req_c.slice  = slice_index;
		req_c.slices = slices;
		req_c.stack  = stack_index;
		req_c.stacks = stacks;
		req_c.side.in_range   = inr;
		req_c.side.quad_valid = qv;
		req_c.side.corner_a   = inr ? ca : '0;
		req_c.side.corner_b   = qv ? ca + 21'd1 : '0;
		req_c.side.corner_c   = qv ? cc : '0;
		req_c.side.corner_d   = qv ? cc + 21'd1 : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (!full) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req_c;
		end
	end

endmodule

[rtl/uvs_queue.sv]
// Short request queue between the front end and the compute pipeline.
`timescale 1ns / 1ps

module uvs_queue #(
	parameter int DEPTH = uvs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  uvs_pkg::req_t wdata,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output uvs_pkg::req_t rdata
);
	import uvs_pkg::*;

	localparam int AW = $clog2(DEPTH);

	req_t              mem_q [DEPTH];
	logic [AW-1:0]     wr_q;
	logic [AW-1:0]     rd_q;
	logic [AW:0]       cnt_q;
	logic              do_pop;

	assign full   = (cnt_q == (AW+1)'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign do_pop = pop && !empty;
	assign rdata  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

[rtl/uvs_div.sv]
// Pipelined restoring divider: floor(x * 2^21 / d) for x <= d, one quotient bit per stage.
`timescale 1ns / 1ps

module uvs_div (
	input  logic                      clk,
	input  logic [uvs_pkg::CNT_W-1:0] x,
	input  logic [uvs_pkg::CNT_W-1:0] d,
	output logic [uvs_pkg::QW-1:0]    q
);
	import uvs_pkg::*;

	logic [CNT_W:0]   r_q  [QW];
	logic [QW-1:0]    qt_q [QW];
	logic [CNT_W-1:0] d_q  [QW];
	logic [CNT_W:0]   r_n  [QW];
	logic [QW-1:0]    qt_n [QW];

	always_comb begin
		logic [CNT_W:0] two;
		logic           bit_k;
		bit_k   = (x >= d);
		r_n[0]  = bit_k ? {1'b0, x} - {1'b0, d} : {1'b0, x};
		qt_n[0] = {bit_k, {(QW-1){1'b0}}};
		for (int k = 1; k < QW; k++) begin
			// remainder stays below d, so the doubled value fits
			two     = {r_q[k-1][CNT_W-1:0], 1'b0};
			bit_k   = (two >= {1'b0, d_q[k-1]});
			r_n[k]  = bit_k ? two - {1'b0, d_q[k-1]} : two;
			qt_n[k] = qt_q[k-1] | (QW'(bit_k) << (QW-1-k));
		end
	end

	always_ff @(posedge clk) begin
		r_q[0]  <= r_n[0];
		qt_q[0] <= qt_n[0];
		d_q[0]  <= d;
		for (int k = 1; k < QW; k++) begin
			r_q[k]  <= r_n[k];
			qt_q[k] <= qt_n[k];
			d_q[k]  <= d_q[k-1];
		end
	end

	assign q = qt_q[QW-1];

endmodule

[rtl/uvs_sine.sv]
// Pipelined sine of a 20-bit turn fraction: quadrant fold, then odd Horner polynomial in Q30.
`timescale 1ns / 1ps

module uvs_sine (
	input  logic                      clk,
	input  logic [uvs_pkg::ANG_W-1:0] ang,
	output logic [uvs_pkg::MAG_W-1:0] mag,
	output logic                      neg
);
	import uvs_pkg::*;

	logic [18:0]      r_c;
	logic [MAG_W-1:0] m_c;
	logic [MAG_W-1:0] t_s1, t_s2, t_s3, t_s4, t_s5, t_s6;
	logic [MAG_W-1:0] t2_s2, t2_s3, t2_s4, t2_s5;
	logic [MAG_W-1:0] p_s3, p_s4, p_s5, p_s6;
	logic [MAG_W-1:0] mag_s7;
	logic [SIN_LAT-1:0] neg_sh_q;

	always_comb begin
		r_c = {1'b0, ang[17:0]};
		if (ang[18]) r_c = 19'(QUARTER_TURN) - r_c;
		m_c = mul_q30(t_s6, p_s6);
	end

	always_ff @(posedge clk) begin
		t_s1   <= {r_c, 12'd0};
		t2_s2  <= mul_q30(t_s1, t_s1);
		t_s2   <= t_s1;
		p_s3   <= SIN_C3 - mul_q30(t2_s2, SIN_C4);
		t2_s3  <= t2_s2;
		t_s3   <= t_s2;
		p_s4   <= SIN_C2 - mul_q30(t2_s3, p_s3);
		t2_s4  <= t2_s3;
		t_s4   <= t_s3;
		p_s5   <= SIN_C1 - mul_q30(t2_s4, p_s4);
		t2_s5  <= t2_s4;
		t_s5   <= t_s4;
		p_s6   <= SIN_C0 - mul_q30(t2_s5, p_s5);
		t_s6   <= t_s5;
		mag_s7 <= (m_c > ONE_Q30) ? ONE_Q30 : m_c;
		neg_sh_q <= {neg_sh_q[SIN_LAT-2:0], ang[19]};
	end

	assign mag = mag_s7;
	assign neg = neg_sh_q[SIN_LAT-1];

endmodule

[rtl/uvs_back.sv]
// Back end: dividers, angle and texture rounding, four sines, products and output register.
`timescale 1ns / 1ps

module uvs_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  uvs_pkg::req_t                     req,
	output logic                              done,
	output logic signed [uvs_pkg::POS_W-1:0]  pos_x,
	output logic signed [uvs_pkg::POS_W-1:0]  pos_y,
	output logic signed [uvs_pkg::POS_W-1:0]  pos_z,
	output logic [uvs_pkg::TEX_W-1:0]         tex_u,
	output logic [uvs_pkg::TEX_W-1:0]         tex_v,
	output logic [uvs_pkg::CRN_W-1:0]         corner_a,
	output logic [uvs_pkg::CRN_W-1:0]         corner_b,
	output logic [uvs_pkg::CRN_W-1:0]         corner_c,
	output logic [uvs_pkg::CRN_W-1:0]         corner_d,
	output logic                              quad_valid,
	output logic                              in_range
);
	import uvs_pkg::*;

	logic [QW-1:0]    qu, qv;
	logic [QW:0]      th_c;
	logic [ANG_W-1:0] phi_s1, theta_s1;
	logic [ANG_W-1:0] phi_q_s1, theta_q_s1;
	logic [TEX_W-1:0] tu_c, tv_c;
	logic [MAG_W-1:0] sp, cp, st, ct;
	logic             nsp, ncp, nst, nct;
	logic [2*MAG_W-1:0] px_s1, pz_s1;
	logic [MAG_W-1:0] cp_s1;
	logic             nx_s1, ny_s1, nz_s1;
	logic [TEX_W-1:0] tu_q [TEX_LAT];
	logic [TEX_W-1:0] tv_q [TEX_LAT];
	side_t            side_q [SIDE_LAT];
	logic [SIDE_LAT-1:0] vld_q;
	logic [2*MAG_W:0] mx_c, mz_c;
	logic [MAG_W:0]   my_c;
	side_t            sd;

	uvs_div u_div_u (.clk(clk), .x(req.slice), .d(req.slices), .q(qu));
	uvs_div u_div_v (.clk(clk), .x(req.stack), .d(req.stacks), .q(qv));

	always_comb begin
		th_c = ({1'b0, qu} + 23'd1) >> 1;
		tu_c = TEX_W'(({1'b0, qu} + 23'd16) >> 5);
		tv_c = TEX_W'(({1'b0, qv} + 23'd16) >> 5);
	end

	// angle stage: round quotients to turn fractions
	always_ff @(posedge clk) begin
		theta_s1   <= th_c[ANG_W-1:0];
		theta_q_s1 <= th_c[ANG_W-1:0] + QUARTER_TURN;
		phi_s1     <= ANG_W'(({1'b0, qv} + 23'd2) >> 2);
		phi_q_s1   <= ANG_W'(({1'b0, qv} + 23'd2) >> 2) + QUARTER_TURN;
		tu_q[0]    <= tu_c;
		tv_q[0]    <= tv_c;
		for (int k = 1; k < TEX_LAT; k++) begin
			tu_q[k] <= tu_q[k-1];
			tv_q[k] <= tv_q[k-1];
		end
	end

	uvs_sine u_sin_p (.clk(clk), .ang(phi_s1),     .mag(sp), .neg(nsp));
	uvs_sine u_cos_p (.clk(clk), .ang(phi_q_s1),   .mag(cp), .neg(ncp));
	uvs_sine u_sin_t (.clk(clk), .ang(theta_s1),   .mag(st), .neg(nst));
	uvs_sine u_cos_t (.clk(clk), .ang(theta_q_s1), .mag(ct), .neg(nct));

	always_ff @(posedge clk) begin
		px_s1 <= {31'd0, sp} * {31'd0, ct};
		pz_s1 <= {31'd0, sp} * {31'd0, st};
		cp_s1 <= cp;
		nx_s1 <= nsp ^ nct;
		ny_s1 <= ncp;
		nz_s1 <= nsp ^ nst;
	end

	// request bookkeeping rides alongside the arithmetic
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			done  <= 1'b0;
		end else begin
			vld_q <= {vld_q[SIDE_LAT-2:0], in_valid};
			done  <= vld_q[SIDE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		side_q[0] <= req.side;
		for (int k = 1; k < SIDE_LAT; k++) begin
			side_q[k] <= side_q[k-1];
		end
	end

	always_comb begin
		sd   = side_q[SIDE_LAT-1];
		mx_c = ({1'b0, px_s1} + (63'd1 << 44)) >> 45;
		mz_c = ({1'b0, pz_s1} + (63'd1 << 44)) >> 45;
		my_c = ({1'b0, cp_s1} + 32'd16384) >> 15;
	end

	always_ff @(posedge clk) begin
		in_range   <= sd.in_range;
		quad_valid <= sd.quad_valid;
		corner_a   <= sd.corner_a;
		corner_b   <= sd.corner_b;
		corner_c   <= sd.corner_c;
		corner_d   <= sd.corner_d;
		pos_x      <= sd.in_range ? sat_sign(mx_c[17:0], nx_s1) : '0;
		pos_y      <= sd.in_range ? sat_sign(my_c[17:0], ny_s1) : '0;
		pos_z      <= sd.in_range ? sat_sign(mz_c[17:0], nz_s1) : '0;
		tex_u      <= sd.in_range ? tu_q[TEX_LAT-1] : '0;
		tex_v      <= sd.in_range ? tv_q[TEX_LAT-1] : '0;
	end

endmodule

[rtl/uvs_checker.sv]
// Port-level checks on results of the UV sphere vertex generator, with its bind.
`timescale 1ns / 1ps

module uvs_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              done,
	input  logic signed [uvs_pkg::POS_W-1:0]  pos_x,
	input  logic signed [uvs_pkg::POS_W-1:0]  pos_y,
	input  logic signed [uvs_pkg::POS_W-1:0]  pos_z,
	input  logic [uvs_pkg::TEX_W-1:0]         tex_u,
	input  logic [uvs_pkg::TEX_W-1:0]         tex_v,
	input  logic [uvs_pkg::CRN_W-1:0]         corner_a,
	input  logic [uvs_pkg::CRN_W-1:0]         corner_b,
	input  logic [uvs_pkg::CRN_W-1:0]         corner_c,
	input  logic [uvs_pkg::CRN_W-1:0]         corner_d,
	input  logic                              quad_valid,
	input  logic                              in_range
);
	import uvs_pkg::*;

	// outside the grid everything is zero
	a_out_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !in_range |-> pos_x == 0 && pos_y == 0 && pos_z == 0 && tex_u == 0
			&& tex_v == 0 && corner_a == 0 && !quad_valid)
		else $error("out-of-grid result not cleared");

	a_quad_links: assert property (@(posedge clk) disable iff (!arst_n)
		done && quad_valid |-> in_range && corner_b == CRN_W'(corner_a + 1'b1)
			&& corner_d == CRN_W'(corner_c + 1'b1))
		else $error("quad corners inconsistent");

	a_edge_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !quad_valid |-> corner_b == 0 && corner_c == 0 && corner_d == 0)
		else $error("edge point carries quad corners");

	// north pole row
	a_pole: assert property (@(posedge clk) disable iff (!arst_n)
		done && in_range && tex_v == 0 |-> pos_y == 16'sd32767)
		else $error("pole y not saturated to one");

endmodule

bind uv_sphere_vertex_generator_core uvs_checker u_uvs_checker (.*);

[dv/tb_top.sv]
// Self-checking testbench for the UV sphere vertex generator core.
`timescale 1ns / 1ps

module tb_top;
	import uvs_pkg::*;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
		logic [TEX_W-1:0]        u;
		logic [TEX_W-1:0]        v;
		logic [CRN_W-1:0]        a;
		logic [CRN_W-1:0]        b;
		logic [CRN_W-1:0]        c;
		logic [CRN_W-1:0]        d;
		logic                    quad;
		logic                    inr;
	} vertex_t;

	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 2'd3;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [IDX_W-1:0] stack_index = '0;
	logic [IDX_W-1:0] slice_index = '0;
	logic done;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic [TEX_W-1:0] tex_u, tex_v;
	logic [CRN_W-1:0] corner_a, corner_b, corner_c, corner_d;
	logic quad_valid, in_range;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CNT_W-1:0] cfg_data = '0;

	logic [CNT_W-1:0] slice_reg = SLICE_RESET;
	logic [CNT_W-1:0] stack_reg = STACK_RESET;
	vertex_t pending_vertices[$];
	int errors = 0;

	uv_sphere_vertex_generator_core dut (.*);

	always #10 clk = ~clk;

	// Taylor terms of sin(pi/2 * t) in Q30
	localparam longint unsigned TAYLOR[5] = '{64'd1686629713, 64'd693598668,
		64'd85569306, 64'd5026995, 64'd172272};

	function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
		return (a * b + (64'd1 << 29)) >> 30;
	endfunction

	function automatic longint unsigned turn_sine(longint unsigned ang, output bit neg);
		longint unsigned q, r, t, t2, p;
		ang = ang & 64'hFFFFF;
		q = (ang >> 18) & 3;
		r = ang & 64'h3FFFF;
		neg = (q >= 2);
		if (q[0]) r = 64'h40000 - r;
		t = r << 12;
		t2 = q30_mul(t, t);
		p = TAYLOR[4];
		for (int k = 3; k >= 0; k--) p = TAYLOR[k] - q30_mul(t2, p);
		p = q30_mul(t, p);
		return (p > (64'd1 << 30)) ? (64'd1 << 30) : p;
	endfunction

	function automatic logic signed [POS_W-1:0] to_q15(longint unsigned m, bit neg);
		logic [POS_W-1:0] s;
		s = (m > 32767) ? 16'd32767 : m[POS_W-1:0];
		if (neg) s = 16'd0 - s;
		return signed'(s);
	endfunction

	function automatic vertex_t sphere_vertex(longint unsigned stack, longint unsigned slice);
		vertex_t e;
		longint unsigned stacks, slices, phi, theta, sp, cp, st, ct;
		bit nsp, ncp, nst, nct;
		e = '0;
		stacks = (stack_reg < MIN_STACKS) ? 64'(MIN_STACKS) :
			(stack_reg > CNT_W'(MAX_DIVISIONS)) ? 64'(MAX_DIVISIONS) : 64'(stack_reg);
		slices = (slice_reg < MIN_SLICES) ? 64'(MIN_SLICES) :
			(slice_reg > CNT_W'(MAX_DIVISIONS)) ? 64'(MAX_DIVISIONS) : 64'(slice_reg);
		if (stack > stacks || slice > slices) return e;
		phi = ((stack << 20) + stacks) / (2 * stacks);
		theta = (((slice << 21) + slices) / (2 * slices)) & 64'hFFFFF;
		sp = turn_sine(phi, nsp);
		cp = turn_sine(phi + 64'h40000, ncp);
		st = turn_sine(theta, nst);
		ct = turn_sine(theta + 64'h40000, nct);
		e.x = to_q15((sp * ct + (64'd1 << 44)) >> 45, nsp != nct);
		e.y = to_q15((cp + (64'd1 << 14)) >> 15, ncp);
		e.z = to_q15((sp * st + (64'd1 << 44)) >> 45, nsp != nst);
		e.u = TEX_W'(((slice << 17) + slices) / (2 * slices));
		e.v = TEX_W'(((stack << 17) + stacks) / (2 * stacks));
		e.a = CRN_W'(stack * (slices + 1) + slice);
		if (stack < stacks && slice < slices) begin
			e.b = CRN_W'(e.a + 1);
			e.c = CRN_W'((stack + 1) * (slices + 1) + slice);
			e.d = CRN_W'(e.c + 1);
			e.quad = 1'b1;
		end
		e.inr = 1'b1;
		return e;
	endfunction

	task automatic report(string field, logic signed [63:0] want_v, logic signed [63:0] got_v);
		$display("%0t: %s exp %0d got %0d", $time, field, want_v, got_v);
		errors++;
	endtask

	// result checker: done is sampled before the edge updates it
	always @(posedge clk) begin
		vertex_t got, want;
		if (arst_n && done) begin
			got = '{pos_x, pos_y, pos_z, tex_u, tex_v, corner_a, corner_b, corner_c,
				corner_d, quad_valid, in_range};
			if (pending_vertices.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
			end else begin
				want = pending_vertices.pop_front();
				if (got.x !== want.x) report("pos_x", 64'(want.x), 64'(got.x));
				if (got.y !== want.y) report("pos_y", 64'(want.y), 64'(got.y));
				if (got.z !== want.z) report("pos_z", 64'(want.z), 64'(got.z));
				if (got.u !== want.u) report("tex_u", 64'(want.u), 64'(got.u));
				if (got.v !== want.v) report("tex_v", 64'(want.v), 64'(got.v));
				if (got.a !== want.a) report("corner_a", 64'(want.a), 64'(got.a));
				if (got.b !== want.b) report("corner_b", 64'(want.b), 64'(got.b));
				if (got.c !== want.c) report("corner_c", 64'(want.c), 64'(got.c));
				if (got.d !== want.d) report("corner_d", 64'(want.d), 64'(got.d));
				if (got.quad !== want.quad)
					report("quad_valid", 64'(want.quad), 64'(got.quad));
				if (got.inr !== want.inr)
					report("in_range", 64'(want.inr), 64'(got.inr));
			end
		end
	end

	// request stays high on return so back-to-back requests need no re-raise
	task automatic send_point(int unsigned stack, int unsigned slice);
		start <= 1;
		stack_index <= stack[IDX_W-1:0];
		slice_index <= slice[IDX_W-1:0];
		do @(posedge clk); while (busy);
		pending_vertices.insert(pending_vertices.size(),
			sphere_vertex(64'(stack[IDX_W-1:0]), 64'(slice[IDX_W-1:0])));
	endtask

	task automatic pause_requests(int unsigned cycles);
		start <= 0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == REG_SLICE_COUNT) slice_reg = val;
		else if (idx == REG_STACK_COUNT) stack_reg = val;
		@(posedge clk);
	endtask

	task automatic set_grid(int unsigned slices, int unsigned stacks);
		drain();
		write_reg(REG_SLICE_COUNT, slices[CNT_W-1:0]);
		write_reg(REG_STACK_COUNT, stacks[CNT_W-1:0]);
	endtask

	task automatic test_defaults();
		send_point(0, 0);
		send_point(16, 32);
		send_point(8, 8);
		send_point(8, 16);
		send_point(15, 31);
		send_point(17, 0);
		send_point(0, 33);
		send_point(2047, 2047);
		pause_requests(3);
	endtask

	task automatic test_corners();
		set_grid(3, 2);
		send_point(0, 0); send_point(1, 1); send_point(2, 3); send_point(1, 3);
		send_point(2, 0); send_point(3, 0);
		set_grid(1024, 1024);
		send_point(1024, 1024); send_point(1023, 1023); send_point(512, 256);
		send_point(1025, 0); send_point(0, 1024);
		// out-of-range counts are clamped; unknown indexes ignored
		set_grid(0, 0);
		write_reg(REG_UNMAPPED_A, 11'd77);
		write_reg(REG_UNMAPPED_B, 11'd500);
		send_point(1, 2); send_point(2, 3); send_point(3, 3);
		set_grid(2047, 1500);
		send_point(1024, 1024); send_point(1024, 1025); send_point(700, 1000);
	endtask

	task automatic random_phase(int unsigned slices, int unsigned stacks, int unsigned count);
		int unsigned n, sl, st, burst, s, l;
		set_grid(slices, stacks);
		s = (stacks < 2) ? 2 : (stacks > 1024) ? 1024 : stacks;
		l = (slices < 3) ? 3 : (slices > 1024) ? 1024 : slices;
		n = 0;
		while (n < count) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst && n < count; i++, n++) begin
				if ($urandom_range(0, 9) < 8) begin
					st = $urandom_range(0, s);
					sl = $urandom_range(0, l);
				end else begin
					st = $urandom_range(0, 2047);
					sl = $urandom_range(0, 2047);
				end
				send_point(st, sl);
			end
			if ($urandom_range(0, 3) != 0) pause_requests($urandom_range(1, 8));
		end
	endtask

	task automatic test_random();
		random_phase(32, 16, 300);
		random_phase(3, 2, 200);
		random_phase(1024, 1024, 300);
		random_phase(1, 0, 150);
		random_phase($urandom_range(3, 64), $urandom_range(2, 64), 400);
		random_phase($urandom_range(3, 1024), $urandom_range(2, 1024), 400);
		random_phase($urandom_range(1025, 2047), $urandom_range(1025, 2047), 150);
		random_phase(7, 5, 100);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_defaults();
		test_corners();
		test_random();
		drain();
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
